/* src/llcp_pkg.sv */
// llcp_pkg: shared types and constants for the line closest-point core
// used by llcp_mul, llcp_div and line_line_closest_points_core; no dependencies
`default_nettype none

package llcp_pkg;

    // digit width of the pipelined multiplier, one digit per stage
    localparam int MUL_DIGIT = 16;

    // per-stage control handed to the pipelined arithmetic units
    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

/* src/llcp_mul.sv */
// llcp_mul: pipelined signed multiplier, one MUL_DIGIT-bit digit of b per stage
// depends on llcp_pkg; carries a side word alongside the product
`default_nettype none

module llcp_mul #(
    parameter int AW = 68,
    parameter int BW = 68,
    parameter int SW = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire llcp_pkg::pipe_ctl_t  ctl,
    input  wire logic signed [AW-1:0] a,
    input  wire logic signed [BW-1:0] b,
    input  wire logic [SW-1:0]        side_in,
    output logic                      out_valid,
    output logic signed [AW+BW-1:0]   prod,
    output logic [SW-1:0]             side_out
);
    import llcp_pkg::*;

    localparam int ND  = (BW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BXW = ND * MUL_DIGIT;
    localparam int PW  = AW + BXW;
    localparam int PPW = AW + MUL_DIGIT + 1;

    logic                  valid_reg [ND];
    logic [SW-1:0]         side_reg  [ND];
    logic signed [AW-1:0]  a_reg     [ND];
    logic signed [BXW-1:0] b_reg     [ND];
    logic signed [PW-1:0]  acc_reg   [ND];

    logic signed [BXW-1:0] b_ext;

    assign b_ext = BXW'(b);

    for (genvar k = 0; k < ND; k++) begin : g_stage
        logic                  valid_src;
        logic [SW-1:0]         side_src;
        logic signed [AW-1:0]  a_src;
        logic signed [BXW-1:0] b_src;
        logic signed [PW-1:0]  acc_src;
        logic [MUL_DIGIT-1:0]  digit;
        logic                  dsgn;
        logic signed [PPW-1:0] pp;
        logic signed [PW-1:0]  acc_next;

        // source of this stage
        if (k == 0) begin : g_first
            assign valid_src = ctl.valid;
            assign side_src  = side_in;
            assign a_src     = a;
            assign b_src     = b_ext;
            assign acc_src   = '0;
        end else begin : g_next
            assign valid_src = valid_reg[k-1];
            assign side_src  = side_reg[k-1];
            assign a_src     = a_reg[k-1];
            assign b_src     = b_reg[k-1];
            assign acc_src   = acc_reg[k-1];
        end

        // one partial product, top digit carries the sign
        assign digit    = b_src[k*MUL_DIGIT +: MUL_DIGIT];
        assign dsgn     = (k == ND - 1) ? digit[MUL_DIGIT-1] : 1'b0;
        assign pp       = a_src * $signed({dsgn, digit});
        assign acc_next = acc_src + (PW'(pp) <<< (k * MUL_DIGIT));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                valid_reg[k] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                side_reg[k] <= side_src;
                a_reg[k]    <= a_src;
                b_reg[k]    <= b_src;
                acc_reg[k]  <= acc_next;
            end
        end
    end

    assign out_valid = valid_reg[ND-1];
    assign prod      = acc_reg[ND-1][AW+BW-1:0];
    assign side_out  = side_reg[ND-1];

endmodule

`default_nettype wire

/* src/llcp_div.sv */
// llcp_div: pipelined signed restoring divider, truncating, saturating quotient
// depends on llcp_pkg; QB quotient bits, one per stage, result clamped to +-2^(QB-1)
`default_nettype none

module llcp_div #(
    parameter int NW = 153,
    parameter int DW = 137,
    parameter int QB = 51,
    parameter int SW = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire llcp_pkg::pipe_ctl_t  ctl,
    input  wire logic signed [NW-1:0] num,
    input  wire logic signed [DW-1:0] den,
    input  wire logic [SW-1:0]        side_in,
    output logic                      out_valid,
    output logic signed [QB:0]        quo,
    output logic [SW-1:0]             side_out
);
    import llcp_pkg::*;

    localparam int RW = DW + 1;
    localparam logic [QB-1:0] LIM = {1'b1, {(QB-1){1'b0}}};

    logic          valid_reg [QB+1];
    logic [SW-1:0] side_reg  [QB+1];
    logic          neg_reg   [QB+1];
    logic          ovf_reg   [QB+1];
    logic [DW-1:0] ud_reg    [QB+1];
    logic [QB-1:0] low_reg   [QB+1];
    logic [RW-1:0] r_reg     [QB+1];
    logic [QB-1:0] q_reg     [QB+1];

    logic          fin_valid_reg;
    logic [SW-1:0] fin_side_reg;
    logic signed [QB:0] fin_quo_reg;

    // setup: magnitudes, sign and overflow test on the high part
    logic          sn;
    logic          sd;
    logic [NW-1:0] un;
    logic [DW-1:0] ud;
    logic [NW-1:0] hi;
    logic          ovf;

    assign sn  = num[NW-1];
    assign sd  = den[DW-1];
    assign un  = sn ? NW'(-num) : NW'(num);
    assign ud  = sd ? DW'(-den) : DW'(den);
    assign hi  = un >> QB;
    assign ovf = ({1'b0, hi} >= (NW+1)'(ud)) || (NW + 1 <= DW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg[0] <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            side_reg[0] <= side_in;
            neg_reg[0]  <= sn ^ sd;
            ovf_reg[0]  <= ovf;
            ud_reg[0]   <= ud;
            low_reg[0]  <= un[QB-1:0];
            r_reg[0]    <= RW'(hi);
            q_reg[0]    <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar i = 1; i <= QB; i++) begin : g_step
        logic [RW-1:0] t;
        logic          ge;
        logic [RW-1:0] r_next;

        assign t      = {r_reg[i-1][RW-2:0], low_reg[i-1][QB-1]};
        assign ge     = t >= RW'(ud_reg[i-1]);
        assign r_next = ge ? (t - RW'(ud_reg[i-1])) : t;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (ctl.advance)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                side_reg[i] <= side_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                ovf_reg[i]  <= ovf_reg[i-1];
                ud_reg[i]   <= ud_reg[i-1];
                low_reg[i]  <= low_reg[i-1] << 1;
                r_reg[i]    <= r_next;
                q_reg[i]    <= {q_reg[i-1][QB-2:0], ge};
            end
        end
    end

    // clamp and restore the sign
    logic [QB-1:0] mag;
    logic [QB:0]   mag_ext;

    assign mag     = (ovf_reg[QB] || (q_reg[QB] > LIM)) ? LIM : q_reg[QB];
    assign mag_ext = {1'b0, mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            fin_valid_reg <= valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            fin_side_reg <= side_reg[QB];
            fin_quo_reg  <= neg_reg[QB] ? $signed(-mag_ext) : $signed(mag_ext);
        end
    end

    assign out_valid = fin_valid_reg;
    assign quo       = fin_quo_reg;
    assign side_out  = fin_side_reg;

endmodule

`default_nettype wire

/* src/line_line_closest_points_core.sv */
// line_line_closest_points_core: closest points between two 3d lines, fixed point
// depends on llcp_pkg, llcp_mul and llcp_div
// throughput: one word per cycle while the output is not stalled; the latency is set by
// the two bit-per-stage dividers and the digit multipliers
// a stall at the output freezes the whole pipeline; no word is lost or repeated
// reset clears only the valid bits; there is no state between words
`default_nettype none

module line_line_closest_points_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [COORD_WIDTH-1:0] line_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] line_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] line_a_start_z,
    input  wire logic signed [COORD_WIDTH-1:0] line_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] line_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] line_a_end_z,
    input  wire logic signed [COORD_WIDTH-1:0] line_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] line_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] line_b_start_z,
    input  wire logic signed [COORD_WIDTH-1:0] line_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] line_b_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] line_b_end_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic signed [COORD_WIDTH-1:0]      near_a_x,
    output logic signed [COORD_WIDTH-1:0]      near_a_y,
    output logic signed [COORD_WIDTH-1:0]      near_a_z,
    output logic signed [COORD_WIDTH-1:0]      near_b_x,
    output logic signed [COORD_WIDTH-1:0]      near_b_y,
    output logic signed [COORD_WIDTH-1:0]      near_b_z
);
    import llcp_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int DFW  = CW + 1;          // coordinate difference
    localparam int PPW  = 2 * DFW;         // one coordinate product
    localparam int DTW  = 2 * CW + 4;      // dot product
    localparam int SQW_W = 2 * DTW;        // product of two dot products
    localparam int NDW  = 2 * DTW + 1;     // denominator and numerator
    localparam int NAW  = NDW + FB;        // scaled numerator
    localparam int QB   = FB + CW + 3;     // quotient bits
    localparam int MW   = QB + 1;          // line parameter
    localparam int NBW  = DTW + MW + 1;    // second dividend
    localparam int PTW  = MW + DFW;        // point product
    localparam int SHW  = PTW - FB;
    localparam int SUMW = SHW + 1;

    typedef logic signed [CW-1:0]  crd_t;
    typedef logic signed [DFW-1:0] dif_t;
    typedef logic signed [DTW-1:0] dot_t;
    typedef logic signed [MW-1:0]  mu_t;

    typedef struct packed {
        crd_t [2:0] a0;
        crd_t [2:0] b0;
        dif_t [2:0] u;
        dif_t [2:0] v;
        dot_t       dwv;
        dot_t       dvu;
        dot_t       dvv;
    } geo_t;

    typedef struct packed {
        geo_t geo;
        logic fnd;
    } aside_t;

    typedef struct packed {
        geo_t geo;
        logic fnd;
        mu_t  mua;
    } bside_t;

    typedef struct packed {
        crd_t [2:0] a0;
        crd_t [2:0] b0;
        logic       fnd;
    } pside_t;

    // global advance: the pipeline moves unless the output word is held
    logic      adv;
    logic      out_valid_reg;
    pipe_ctl_t ctl_m1;
    pipe_ctl_t ctl_da;
    pipe_ctl_t ctl_mb;
    pipe_ctl_t ctl_db;
    pipe_ctl_t ctl_mp;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // stage 1: differences
    crd_t a0_c [3];
    crd_t a1_c [3];
    crd_t b0_c [3];
    crd_t b1_c [3];

    assign a0_c[0] = line_a_start_x;
    assign a0_c[1] = line_a_start_y;
    assign a0_c[2] = line_a_start_z;
    assign a1_c[0] = line_a_end_x;
    assign a1_c[1] = line_a_end_y;
    assign a1_c[2] = line_a_end_z;
    assign b0_c[0] = line_b_start_x;
    assign b0_c[1] = line_b_start_y;
    assign b0_c[2] = line_b_start_z;
    assign b1_c[0] = line_b_end_x;
    assign b1_c[1] = line_b_end_y;
    assign b1_c[2] = line_b_end_z;

    logic       v1_reg;
    crd_t [2:0] a0_1_reg;
    crd_t [2:0] b0_1_reg;
    dif_t [2:0] u_1_reg;
    dif_t [2:0] v_1_reg;
    dif_t [2:0] w_1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a0_1_reg[i] <= a0_c[i];
                b0_1_reg[i] <= b0_c[i];
                u_1_reg[i]  <= DFW'(a1_c[i]) - DFW'(a0_c[i]);
                v_1_reg[i]  <= DFW'(b1_c[i]) - DFW'(b0_c[i]);
                w_1_reg[i]  <= DFW'(a0_c[i]) - DFW'(b0_c[i]);
            end
        end
    end

    // stage 2: coordinate products (wv, vu, wu, vv, uu)
    logic              v2_reg;
    crd_t [2:0]        a0_2_reg;
    crd_t [2:0]        b0_2_reg;
    dif_t [2:0]        u_2_reg;
    dif_t [2:0]        v_2_reg;
    logic signed [PPW-1:0] pr_reg [5][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_2_reg <= a0_1_reg;
            b0_2_reg <= b0_1_reg;
            u_2_reg  <= u_1_reg;
            v_2_reg  <= v_1_reg;
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[0][i] <= $signed(w_1_reg[i]) * $signed(v_1_reg[i]);
                pr_reg[1][i] <= $signed(v_1_reg[i]) * $signed(u_1_reg[i]);
                pr_reg[2][i] <= $signed(w_1_reg[i]) * $signed(u_1_reg[i]);
                pr_reg[3][i] <= $signed(v_1_reg[i]) * $signed(v_1_reg[i]);
                pr_reg[4][i] <= $signed(u_1_reg[i]) * $signed(u_1_reg[i]);
            end
        end
    end

    // stage 3: dot products
    logic v3_reg;
    geo_t geo_3_reg;
    dot_t dwu_3_reg;
    dot_t duu_3_reg;
    dot_t dsum [5];

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            dsum[k] = DTW'(pr_reg[k][0]) + DTW'(pr_reg[k][1]) + DTW'(pr_reg[k][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo_3_reg.a0  <= a0_2_reg;
            geo_3_reg.b0  <= b0_2_reg;
            geo_3_reg.u   <= u_2_reg;
            geo_3_reg.v   <= v_2_reg;
            geo_3_reg.dwv <= dsum[0];
            geo_3_reg.dvu <= dsum[1];
            geo_3_reg.dvv <= dsum[3];
            dwu_3_reg     <= dsum[2];
            duu_3_reg     <= dsum[4];
        end
    end

    // second-order products for the determinant and numerator
    logic                   m1_valid;
    geo_t                   geo_m1;
    logic signed [SQW_W-1:0] p_uuvv;
    logic signed [SQW_W-1:0] p_vuvu;
    logic signed [SQW_W-1:0] p_wvvu;
    logic signed [SQW_W-1:0] p_wuvv;

    assign ctl_m1 = '{advance: adv, valid: v3_reg};

    llcp_mul #(.AW(DTW), .BW(DTW), .SW($bits(geo_t))) u_mul_uuvv (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_m1),
        .a(duu_3_reg), .b(geo_3_reg.dvv), .side_in(geo_3_reg),
        .out_valid(m1_valid), .prod(p_uuvv), .side_out(geo_m1)
    );

    llcp_mul #(.AW(DTW), .BW(DTW), .SW(1)) u_mul_vuvu (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_m1),
        .a(geo_3_reg.dvu), .b(geo_3_reg.dvu), .side_in(1'b0),
        .out_valid(), .prod(p_vuvu), .side_out()
    );

    llcp_mul #(.AW(DTW), .BW(DTW), .SW(1)) u_mul_wvvu (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_m1),
        .a(geo_3_reg.dwv), .b(geo_3_reg.dvu), .side_in(1'b0),
        .out_valid(), .prod(p_wvvu), .side_out()
    );

    llcp_mul #(.AW(DTW), .BW(DTW), .SW(1)) u_mul_wuvv (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_m1),
        .a(dwu_3_reg), .b(geo_3_reg.dvv), .side_in(1'b0),
        .out_valid(), .prod(p_wuvv), .side_out()
    );

    // stage 4: determinant, numerator and the degenerate test
    logic                  v4_reg;
    aside_t                as_4_reg;
    logic signed [NDW-1:0] denom_4_reg;
    logic signed [NDW-1:0] numer_4_reg;
    logic signed [NDW-1:0] denom_c;

    assign denom_c = NDW'(p_uuvv) - NDW'(p_vuvu);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= m1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            as_4_reg.geo <= geo_m1;
            as_4_reg.fnd <= (denom_c != '0) && (geo_m1.dvv != '0);
            denom_4_reg  <= denom_c;
            numer_4_reg  <= NDW'(p_wvvu) - NDW'(p_wuvv);
        end
    end

    // first line parameter
    logic                  da_valid;
    aside_t                as_da;
    logic signed [QB:0]    mua_q;
    logic signed [NAW-1:0] num_a;

    assign ctl_da = '{advance: adv, valid: v4_reg};
    assign num_a  = $signed({numer_4_reg, {FB{1'b0}}});

    llcp_div #(.NW(NAW), .DW(NDW), .QB(QB), .SW($bits(aside_t))) u_div_a (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_da),
        .num(num_a), .den(denom_4_reg), .side_in(as_4_reg),
        .out_valid(da_valid), .quo(mua_q), .side_out(as_da)
    );

    // dvu * mua
    logic                       mb_valid;
    bside_t                     bs_in;
    bside_t                     bs_mb;
    logic signed [DTW+MW-1:0]   p_vumu;

    assign ctl_mb    = '{advance: adv, valid: da_valid};
    assign bs_in.geo = as_da.geo;
    assign bs_in.fnd = as_da.fnd;
    assign bs_in.mua = mua_q;

    llcp_mul #(.AW(DTW), .BW(MW), .SW($bits(bside_t))) u_mul_vumu (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_mb),
        .a(as_da.geo.dvu), .b(mua_q), .side_in(bs_in),
        .out_valid(mb_valid), .prod(p_vumu), .side_out(bs_mb)
    );

    // stage 5: second dividend
    logic                  v5_reg;
    bside_t                bs_5_reg;
    logic signed [NBW-1:0] num_b_5_reg;
    logic signed [DTW+FB-1:0] wv_sh;

    assign wv_sh = $signed({bs_mb.geo.dwv, {FB{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= mb_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bs_5_reg    <= bs_mb;
            num_b_5_reg <= NBW'(wv_sh) + NBW'(p_vumu);
        end
    end

    // second line parameter
    logic               db_valid;
    bside_t             bs_db;
    logic signed [QB:0] mub_q;

    assign ctl_db = '{advance: adv, valid: v5_reg};

    llcp_div #(.NW(NBW), .DW(DTW), .QB(QB), .SW($bits(bside_t))) u_div_b (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_db),
        .num(num_b_5_reg), .den(bs_5_reg.geo.dvv), .side_in(bs_5_reg),
        .out_valid(db_valid), .quo(mub_q), .side_out(bs_db)
    );

    // point products mua*u and mub*v
    logic                  mp_valid;
    pside_t                ps_in;
    pside_t                ps_mp;
    logic signed [PTW-1:0] pa_prod [3];
    logic signed [PTW-1:0] pb_prod [3];

    assign ctl_mp   = '{advance: adv, valid: db_valid};
    assign ps_in.a0 = bs_db.geo.a0;
    assign ps_in.b0 = bs_db.geo.b0;
    assign ps_in.fnd = bs_db.fnd;

    llcp_mul #(.AW(MW), .BW(DFW), .SW($bits(pside_t))) u_mul_pa0 (
        .clk(clk), .rst_n(rst_n), .ctl(ctl_mp),
        .a(bs_db.mua), .b(bs_db.geo.u[0]), .side_in(ps_in),
        .out_valid(mp_valid), .prod(pa_prod[0]), .side_out(ps_mp)
    );

    for (genvar i = 1; i < 3; i++) begin : g_pa
        llcp_mul #(.AW(MW), .BW(DFW), .SW(1)) u_mul_pa (
            .clk(clk), .rst_n(rst_n), .ctl(ctl_mp),
            .a(bs_db.mua), .b(bs_db.geo.u[i]), .side_in(1'b0),
            .out_valid(), .prod(pa_prod[i]), .side_out()
        );
    end

    for (genvar i = 0; i < 3; i++) begin : g_pb
        llcp_mul #(.AW(MW), .BW(DFW), .SW(1)) u_mul_pb (
            .clk(clk), .rst_n(rst_n), .ctl(ctl_mp),
            .a(mub_q), .b(bs_db.geo.v[i]), .side_in(1'b0),
            .out_valid(), .prod(pb_prod[i]), .side_out()
        );
    end

    // saturate a wide sum to the coordinate range
    function automatic logic [CW-1:0] sat_crd(input logic signed [SUMW-1:0] x);
        logic [SUMW-CW:0] top;
        logic [CW-1:0]    res;
        top = x[SUMW-1:CW-1];
        if ((&top) || !(|top))
        begin
            res = x[CW-1:0];
        end
        else if (x[SUMW-1])
        begin
            res = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

    // stage 6: shift, add start point, saturate; output register
    logic [CW-1:0] pa_c [3];
    logic [CW-1:0] pb_c [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_c[i] = sat_crd(SUMW'(SHW'(pa_prod[i] >>> FB)) + SUMW'(ps_mp.a0[i]));
            pb_c[i] = sat_crd(SUMW'(SHW'(pb_prod[i] >>> FB)) + SUMW'(ps_mp.b0[i]));
        end
    end

    logic          found_reg;
    logic [CW-1:0] pa_reg [3];
    logic [CW-1:0] pb_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= mp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg <= ps_mp.fnd;
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= ps_mp.fnd ? pa_c[i] : '0;
                pb_reg[i] <= ps_mp.fnd ? pb_c[i] : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign near_a_x  = pa_reg[0];
    assign near_a_y  = pa_reg[1];
    assign near_a_z  = pa_reg[2];
    assign near_b_x  = pb_reg[0];
    assign near_b_y  = pb_reg[1];
    assign near_b_z  = pb_reg[2];

    // a word without a solution carries zero coordinates
    a_zero_when_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> near_a_x == '0 && near_a_y == '0 && near_a_z == '0
                                && near_b_x == '0 && near_b_y == '0 && near_b_z == '0)
        else $error("coordinates not cleared for a word without solution");

    // an accepted word enters the first stage
    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted word lost at entry");

    // out_valid only rises while the pipeline advances
    a_out_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("output word appeared during a stall");

endmodule

`default_nettype wire

/* test/tb_line_line_closest_points_core.sv */
// tb_line_line_closest_points_core: self-checking bench for the line closest-point core
// depends on line_line_closest_points_core (and through it llcp_pkg); wide-integer
// predictor with a scoreboard class, random idling on both sides
`default_nettype none

module tb_line_line_closest_points_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int N_RANDOM    = 430;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] c[12];
    } line_pair_t;

    typedef struct {
        logic                          found;
        logic signed [COORD_WIDTH-1:0] pt[6];
    } near_points_t;

    // closest points of two lines, exact wide arithmetic
    function automatic near_points_t closest_points(line_pair_t l);
        wide_t a0[3], b0[3], u[3], v[3], w[3];
        wide_t d_wv, d_vu, d_wu, d_vv, d_uu, denom, numer, mua, mub, lim, p, hi, lo;
        near_points_t r;
        r.found = 1'b0;
        for (int i = 0; i < 6; i++) r.pt[i] = '0;
        for (int i = 0; i < 3; i++)
        begin
            a0[i] = l.c[i];
            u[i]  = wide_t'(l.c[3+i]) - a0[i];
            b0[i] = l.c[6+i];
            v[i]  = wide_t'(l.c[9+i]) - b0[i];
            w[i]  = a0[i] - b0[i];
        end
        d_wv = w[0]*v[0] + w[1]*v[1] + w[2]*v[2];
        d_vu = v[0]*u[0] + v[1]*u[1] + v[2]*u[2];
        d_wu = w[0]*u[0] + w[1]*u[1] + w[2]*u[2];
        d_vv = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        d_uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        denom = d_uu*d_vv - d_vu*d_vu;
        if (denom == 0 || d_vv == 0)
            return r;
        numer = d_wv*d_vu - d_wu*d_vv;
        lim = wide_t'(1) <<< (FRAC_BITS + COORD_WIDTH + 2);
        mua = (numer <<< FRAC_BITS) / denom;
        if (mua > lim) mua = lim;
        if (mua < -lim) mua = -lim;
        mub = ((d_wv <<< FRAC_BITS) + d_vu*mua) / d_vv;
        if (mub > lim) mub = lim;
        if (mub < -lim) mub = -lim;
        hi = (wide_t'(1) <<< (COORD_WIDTH-1)) - 1;
        lo = -(wide_t'(1) <<< (COORD_WIDTH-1));
        for (int i = 0; i < 3; i++)
        begin
            p = a0[i] + ((mua*u[i]) >>> FRAC_BITS);
            if (p > hi) p = hi;
            if (p < lo) p = lo;
            r.pt[i] = p[COORD_WIDTH-1:0];
            p = b0[i] + ((mub*v[i]) >>> FRAC_BITS);
            if (p > hi) p = hi;
            if (p < lo) p = lo;
            r.pt[3+i] = p[COORD_WIDTH-1:0];
        end
        r.found = 1'b1;
        return r;
    endfunction

    // expected near points in acceptance order
    class near_point_board;
        near_points_t pending_q[$];
        int errors = 0;

        function void note_word(line_pair_t l);
            pending_q.push_back(closest_points(l));
        endfunction

        function void check_word(near_points_t got);
            near_points_t exp_r;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected", $time);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.found !== exp_r.found)
            begin
                $display("%0t: found expected %0b actual %0b", $time, exp_r.found, got.found);
                errors++;
            end
            for (int i = 0; i < 6; i++)
                if (got.pt[i] !== exp_r.pt[i])
                begin
                    $display("%0t: coord %0d expected %0d actual %0d",
                             $time, i, exp_r.pt[i], got.pt[i]);
                    errors++;
                end
        endfunction
    endclass

    logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, found;
    logic signed [COORD_WIDTH-1:0] c_in[12];
    logic signed [COORD_WIDTH-1:0] near_a_x, near_a_y, near_a_z;
    logic signed [COORD_WIDTH-1:0] near_b_x, near_b_y, near_b_z;
    near_point_board board;
    logic hold_req;
    int   cycles;

    line_line_closest_points_core #(
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .line_a_start_x(c_in[0]),
        .line_a_start_y(c_in[1]),
        .line_a_start_z(c_in[2]),
        .line_a_end_x  (c_in[3]),
        .line_a_end_y  (c_in[4]),
        .line_a_end_z  (c_in[5]),
        .line_b_start_x(c_in[6]),
        .line_b_start_y(c_in[7]),
        .line_b_start_z(c_in[8]),
        .line_b_end_x  (c_in[9]),
        .line_b_end_y  (c_in[10]),
        .line_b_end_z  (c_in[11]),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .near_a_x      (near_a_x),
        .near_a_y      (near_a_y),
        .near_a_z      (near_a_z),
        .near_b_x      (near_b_x),
        .near_b_y      (near_b_y),
        .near_b_z      (near_b_z)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one coordinate, mixing full range, small values and extremes
    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom;
        if (r < 85) return $signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000;
        if (r < 92) return 32'sh7FFF_FFFF;
        return 32'sh8000_0000;
    endfunction

    // random line pair; some parallel, some degenerate
    function automatic line_pair_t rand_pair();
        line_pair_t l;
        int kind, k;
        for (int i = 0; i < 12; i++) l.c[i] = rand_coord();
        kind = $urandom_range(0, 99);
        k = $urandom_range(1, 4);
        if (kind < 8)
            for (int i = 0; i < 3; i++)
            begin
                l.c[i]   = $signed($urandom_range(0, 20000)) - 10000;
                l.c[3+i] = $signed($urandom_range(0, 20000)) - 10000;
                l.c[9+i] = l.c[6+i] + k * (l.c[3+i] - l.c[i]);
            end
        else if (kind < 13)
            for (int i = 0; i < 3; i++) l.c[9+i] = l.c[6+i];
        else if (kind < 17)
            for (int i = 0; i < 3; i++) l.c[3+i] = l.c[i];
        return l;
    endfunction

    function automatic line_pair_t make_pair(int s, int ax, int ay, int az, int bx,
                                             int by, int bz);
        line_pair_t l;
        for (int i = 0; i < 12; i++) l.c[i] = '0;
        l.c[0] = 0;  l.c[1] = 0;  l.c[2] = 0;
        l.c[3] = ax; l.c[4] = ay; l.c[5] = az;
        l.c[6] = 0;  l.c[7] = 0;  l.c[8] = s;
        l.c[9] = bx; l.c[10] = by; l.c[11] = s + bz;
        return l;
    endfunction

    // offer one word and wait for it to be taken
    task automatic send_word(line_pair_t l);
        int gap;
        for (int i = 0; i < 12; i++) c_in[i] <= l.c[i];
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_word(l);
        gap = hold_req ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: check, then choose the next stall
    initial
    begin
        int hold_left, calm_left;
        near_points_t got;
        hold_left = 0;
        calm_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.found = found;
                got.pt[0] = near_a_x; got.pt[1] = near_a_y; got.pt[2] = near_a_z;
                got.pt[3] = near_b_x; got.pt[4] = near_b_y; got.pt[5] = near_b_z;
                board.check_word(got);
            end
            if (hold_req && hold_left == 0)
                hold_left = 400;
            if (hold_left > 1)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_left == 1)
            begin
                hold_left = 0;
                out_stall <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 30);
                if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
                if ($urandom_range(0, 199) == 0) hold_left = $urandom_range(20, 60);
            end
        end
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("line_line_closest_points_core test failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        line_pair_t l;
        board = new();
        hold_req = 1'b0;
        in_valid = 1'b0;
        for (int i = 0; i < 12; i++) c_in[i] = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, parallel, perpendicular, extremes
        for (int i = 0; i < 12; i++) l.c[i] = '0;
        send_word(l);
        send_word(make_pair(65536, 65536, 0, 0, 0, 65536, 0));
        send_word(make_pair(65536, 65536, 0, 0, 131072, 0, 0));
        send_word(make_pair(65536, 0, 0, 0, 0, 65536, 0));
        send_word(make_pair(0, 65536, 65536, 0, 65536, 65536, 0));
        send_word(make_pair(-300000, 65536, 3, -7, -5, 65536, 11));
        send_word(make_pair(1, 1, 0, 0, 0, 1, 0));
        send_word(make_pair(0, 65536, 0, 0, 65536, 1, 0));
        for (int i = 0; i < 12; i++) l.c[i] = 32'sh7FFF_FFFF;
        send_word(l);
        for (int i = 0; i < 12; i++) l.c[i] = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        send_word(l);
        for (int i = 0; i < 12; i++) l.c[i] = (i % 3) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        send_word(l);
        for (int i = 0; i < 12; i++) l.c[i] = (i < 6) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        l.c[3] = 32'sh7FFF_FFFF;
        l.c[10] = 32'sh8000_0000;
        send_word(l);
        // far lines with short direction vectors push the points into saturation
        l = make_pair(32'sh4000_0000, 1, 0, 0, 1, 1, 0);
        l.c[6] = 32'sh8000_0000;
        send_word(l);
        l = make_pair(-32'sh4000_0000, 2, 1, 0, 1, 0, 0);
        send_word(l);
        for (int k = 0; k < 6; k++) send_word(rand_pair());

        // sender waits until everything has drained
        in_valid <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge clk);

        // random part, with a long receiver hold-off partway through
        for (int n = 0; n < N_RANDOM; n++)
        begin
            hold_req = (n >= 150 && n < 260);
            send_word(rand_pair());
            if (n == 300)
            begin
                in_valid <= 1'b0;
                while (board.pending_q.size() != 0) @(posedge clk);
            end
        end
        hold_req = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("line_line_closest_points_core test passed");
        else
            $display("line_line_closest_points_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
